FILE: rtl/icmp_echo_pkg.sv
// shared types and constants for the icmp echo responder
// used by the front, queue, back and top level; no dependencies
package icmp_echo_pkg;

    // message byte count width, wide enough for counts up to 127 bytes
    localparam int LEN_W = 7;

    localparam logic [7:0]       ECHO_REQUEST_TYPE = 8'd8;
    localparam logic [LEN_W-1:0] MIN_MESSAGE_BYTES = 7'd8;
    localparam logic [LEN_W-1:0] SHARED_FROM_BYTE  = 7'd4;
    localparam logic [15:0]      SUM_ALL_ONES      = 16'hFFFF;

    // reply index of each checksum byte
    localparam logic [LEN_W-1:0] IDX_CK_HI = 7'd2;
    localparam logic [LEN_W-1:0] IDX_CK_LO = 7'd3;

    // one accepted request waiting to be answered
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic [15:0]      ck;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SEND
    } t_back_state;

endpackage

FILE: rtl/icmp_echo_responder_unit.sv
// top level of the icmp echo responder
// instantiates icmp_echo_front, icmp_echo_queue, icmp_echo_back, icmp_echo_ram
//
// Takes an ICMP message one byte per item (tlast on the final byte) and, if it
// is a valid echo request of 8 to MAX_BYTES bytes whose checksum verifies,
// sends the echo reply: type 0, code 0, recomputed checksum, then the request
// bytes from byte 4 on, tlast on the final byte. Anything else, including a
// message longer than MAX_BYTES, is dropped without output. Receive takes one
// byte per cycle; each reply byte is read from the store, then presented.
// The store has two banks, so one message can load while the previous reply
// drains; input stalls only while both banks hold replies not yet sent.
module icmp_echo_responder_unit #(
    parameter int MAX_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [7:0] out_byte
    output logic       o_m_tlast
);
    import icmp_echo_pkg::*;

    localparam int AW = $clog2(MAX_BYTES) + 1;

    logic          w_push;
    logic          w_pop;
    t_job          w_job_in;
    t_job          w_head;
    logic          w_q_empty;
    logic          w_q_full;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;

    icmp_echo_front #(.MAX_BYTES(MAX_BYTES)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_job    (w_job_in),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata)
    );

    icmp_echo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    icmp_echo_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    icmp_echo_back #(.MAX_BYTES(MAX_BYTES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_q_empty),
        .i_job   (w_head),
        .o_pop   (w_pop),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

    // a reply byte is only ever shown for a job held in the queue
    a_valid_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !w_q_empty)
        else $error("reply item shown with no job queued");

    // a new job never lands in a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("job pushed into a full queue");

    // after the final reply byte goes out, valid is low in the following cycle
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> !o_m_tvalid)
        else $error("reply item shown straight after final item");

endmodule

FILE: rtl/icmp_echo_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module icmp_echo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/icmp_echo_front.sv
// receive side: stores message bytes into one store bank, keeps both sums
// and checks the request on its last byte; uses icmp_echo_pkg
module icmp_echo_front #(
    parameter int MAX_BYTES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [7:0]                           i_byte,
    input  logic                                 i_last,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output icmp_echo_pkg::t_job                  o_job,
    output logic                                 o_we,
    output logic [$clog2(MAX_BYTES):0]           o_waddr,
    output logic [7:0]                           o_wdata
);
    import icmp_echo_pkg::*;

    localparam int PW = $clog2(MAX_BYTES);

    logic [LEN_W-1:0] r_count, n_count;
    logic [15:0]      r_req_sum, n_req_sum;
    logic [15:0]      r_rep_sum, n_rep_sum;
    logic [7:0]       r_pending, n_pending;
    logic             r_ovf, n_ovf;
    logic             r_type_ok, n_type_ok;
    logic             r_bank;

    logic             w_hs;
    logic             w_store;
    logic             w_add;
    logic             w_shared;
    logic [15:0]      w_word;
    logic             w_good;

    // ones'-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // new items wait while both store banks hold replies
    assign o_ready = !i_q_full;
    assign w_hs    = i_valid && o_ready;

    // per-byte sum and store update
    always_comb begin
        w_store   = (r_count < LEN_W'(MAX_BYTES)) && !r_ovf;
        w_add     = w_store && (r_count[0] || i_last);
        w_shared  = r_count >= SHARED_FROM_BYTE;
        w_word    = r_count[0] ? {r_pending, i_byte} : {i_byte, 8'h00};
        n_req_sum = w_add ? oc_add(r_req_sum, w_word) : r_req_sum;
        n_rep_sum = (w_add && w_shared) ? oc_add(r_rep_sum, w_word) : r_rep_sum;
        n_pending = (w_store && !r_count[0]) ? i_byte : r_pending;
        n_count   = w_store ? r_count + 7'd1 : r_count;
        n_ovf     = r_ovf || !w_store;
        n_type_ok = (w_store && r_count == '0) ? (i_byte == ECHO_REQUEST_TYPE) : r_type_ok;
    end

    // acceptance check on the last byte
    assign w_good = !n_ovf && n_count >= MIN_MESSAGE_BYTES
                    && n_count <= LEN_W'(MAX_BYTES)
                    && n_type_ok && n_req_sum == SUM_ALL_ONES;

    assign o_push     = w_hs && i_last && w_good;
    assign o_job.bank = r_bank;
    assign o_job.len  = n_count;
    assign o_job.ck   = ~n_rep_sum;

    assign o_we    = w_hs && w_store;
    assign o_waddr = {r_bank, r_count[PW-1:0]};
    assign o_wdata = i_byte;

    // message state, cleared after every last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_req_sum <= '0;
            r_rep_sum <= '0;
            r_pending <= '0;
            r_ovf     <= 1'b0;
            r_type_ok <= 1'b0;
            r_bank    <= 1'b0;
        end else if (w_hs) begin
            if (i_last) begin
                r_count   <= '0;
                r_req_sum <= '0;
                r_rep_sum <= '0;
                r_pending <= '0;
                r_ovf     <= 1'b0;
                r_type_ok <= 1'b0;
                if (w_good) begin
                    r_bank <= !r_bank;
                end
            end else begin
                r_count   <= n_count;
                r_req_sum <= n_req_sum;
                r_rep_sum <= n_rep_sum;
                r_pending <= n_pending;
                r_ovf     <= n_ovf;
                r_type_ok <= n_type_ok;
            end
        end
    end

endmodule

FILE: rtl/icmp_echo_queue.sv
// two-entry job queue between the receive and reply sides
// uses icmp_echo_pkg
module icmp_echo_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  icmp_echo_pkg::t_job i_job,
    input  logic                i_pop,
    output icmp_echo_pkg::t_job o_head,
    output logic                o_empty,
    output logic                o_full
);
    import icmp_echo_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = r_cnt == 2'd0;
    assign o_full  = r_cnt == 2'd2;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/icmp_echo_back.sv
// reply side: reads the stored request out of its bank and sends the reply
// with the new header; uses icmp_echo_pkg
module icmp_echo_back #(
    parameter int MAX_BYTES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  icmp_echo_pkg::t_job        i_job,
    output logic                       o_pop,
    output logic [$clog2(MAX_BYTES):0] o_raddr,
    input  logic [7:0]                 i_rdata,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_byte,
    output logic                       o_last
);
    import icmp_echo_pkg::*;

    localparam int PW = $clog2(MAX_BYTES);

    t_back_state      r_state, n_state;
    logic [LEN_W-1:0] r_idx;
    logic             w_last;
    logic             w_hs;

    assign w_last = (r_idx + 7'd1) == i_job.len;
    assign w_hs   = o_valid && i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_ready) begin
                    n_state = w_last ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs; the store address stays on the current byte while it is shown
    always_comb begin
        o_valid = 1'b0;
        o_pop   = 1'b0;
        case (r_state)
            S_SEND: begin
                o_valid = 1'b1;
                o_pop   = i_ready && w_last;
            end
            default: begin
                o_valid = 1'b0;
                o_pop   = 1'b0;
            end
        endcase
    end

    assign o_raddr = {i_job.bank, r_idx[PW-1:0]};
    assign o_last  = w_last;

    // reply byte: type and code zero, new checksum, rest from the store
    always_comb begin
        if (r_idx < IDX_CK_HI) begin
            o_byte = 8'h00;
        end else if (r_idx == IDX_CK_HI) begin
            o_byte = i_job.ck[15:8];
        end else if (r_idx == IDX_CK_LO) begin
            o_byte = i_job.ck[7:0];
        end else begin
            o_byte = i_rdata;
        end
    end

    // state and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_idx <= '0;
            end else if (w_hs) begin
                r_idx <= r_idx + 7'd1;
            end
        end
    end

endmodule

FILE: tb/sv/icmp_echo_reply_checker.sv
// checker for the icmp echo responder: watches both item channels, predicts replies
// keeps its own copy of the message store and checksum sums; needs icmp_echo_pkg
module icmp_echo_reply_checker #(
    parameter int MAX_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] in_byte
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,    // [7:0] out_byte
    input  logic       i_m_tlast,
    output int         o_mismatches,
    output int         o_waiting,
    output int         o_replies_seen,
    output int         o_dropped
);
    import icmp_echo_pkg::*;

    localparam logic [7:0] ECHO_REPLY_TYPE = 8'd0;
    localparam logic [7:0] ECHO_REPLY_CODE = 8'd0;
    localparam int         CW              = $clog2(MAX_BYTES);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_reply_item;

    // predicted receive state
    logic [7:0]       message_copy [0:MAX_BYTES-1];
    logic [LEN_W-1:0] bytes_held;
    logic [15:0]      whole_sum;
    logic [15:0]      shared_sum;
    logic [7:0]       high_half;
    logic             too_long;

    t_reply_item reply_items [$];
    int mismatches;
    int replies_seen;
    int dropped;

    function automatic logic [15:0] ones_sum_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    task automatic restart_message();
        bytes_held = '0;
        whole_sum  = '0;
        shared_sum = '0;
        high_half  = '0;
        too_long   = 1'b0;
    endtask

    // fold one request item into the sums and, on its last item, predict the reply
    task automatic absorb_request_item(input logic [7:0] data, input logic last);
        logic [LEN_W-1:0] pos;
        logic [15:0]      word;
        logic [15:0]      reply_ck;
        t_reply_item      item;
        int               n;
        pos = bytes_held;
        if (int'(pos) < MAX_BYTES && !too_long) begin
            message_copy[pos[CW-1:0]] = data;
            bytes_held = pos + 1'b1;
            if (!pos[0]) begin
                high_half = data;
            end
            // odd final item is the high half of a zero-padded word
            if (pos[0] || last) begin
                word = pos[0] ? {high_half, data} : {data, 8'h00};
                whole_sum = ones_sum_add(whole_sum, word);
                if (pos >= SHARED_FROM_BYTE) begin
                    shared_sum = ones_sum_add(shared_sum, word);
                end
            end
        end else begin
            too_long = 1'b1;
        end
        if (last) begin
            n = int'(bytes_held);
            if (!too_long && bytes_held >= MIN_MESSAGE_BYTES && n <= MAX_BYTES &&
                message_copy[0] == ECHO_REQUEST_TYPE && whole_sum == SUM_ALL_ONES) begin
                reply_ck = ~shared_sum;
                for (int i = 0; i < n; i++) begin
                    if (i == 0)
                        item.data = ECHO_REPLY_TYPE;
                    else if (i == 1)
                        item.data = ECHO_REPLY_CODE;
                    else if (i == int'(IDX_CK_HI))
                        item.data = reply_ck[15:8];
                    else if (i == int'(IDX_CK_LO))
                        item.data = reply_ck[7:0];
                    else
                        item.data = message_copy[CW'(i)];
                    item.last = (i == n - 1);
                    reply_items.push_back(item);
                end
            end else begin
                dropped++;
            end
            restart_message();
        end
    endtask

    // compare one reply item with the oldest prediction
    task automatic check_reply_item(input logic [7:0] data, input logic last);
        t_reply_item want;
        if (reply_items.size() == 0) begin
            mismatches++;
            $display("%0t: reply item with none expected: data %02h last %0b",
                     $time, data, last);
        end else begin
            want = reply_items.pop_front();
            if (data !== want.data) begin
                mismatches++;
                $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
            end
            if (last !== want.last) begin
                mismatches++;
                $display("%0t: out_last expected %0b actual %0b", $time, want.last, last);
            end
            if (want.last) begin
                replies_seen++;
            end
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_message();
            reply_items.delete();
            mismatches   = 0;
            replies_seen = 0;
            dropped      = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_reply_item(i_m_tdata, i_m_tlast);
            end
            if (i_s_tvalid && i_s_tready) begin
                absorb_request_item(i_s_tdata, i_s_tlast);
            end
        end
        o_mismatches   <= mismatches;
        o_waiting      <= reply_items.size();
        o_replies_seen <= replies_seen;
        o_dropped      <= dropped;
    end

endmodule

FILE: tb/sv/icmp_echo_responder_unit_test.sv
// testbench top for icmp_echo_responder_unit: clock, reset, request stimulus, verdict
// depends on icmp_echo_pkg, icmp_echo_responder_unit and icmp_echo_reply_checker
module icmp_echo_responder_unit_test;
    import icmp_echo_pkg::*;

    localparam int MAX_BYTES   = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 180;
    localparam int CALM_FROM    = 140;
    localparam logic [7:0] ECHO_REPLY_TYPE = 8'd0;

    typedef enum {
        MSG_ECHO,
        MSG_FULL,
        MSG_LONG,
        MSG_SHORT,
        MSG_BAD_SUM,
        MSG_WRONG_TYPE,
        MSG_NOISE
    } t_msg_kind;

    logic       i_clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b1;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;

    int mismatches;
    int waiting;
    int replies_seen;
    int dropped;

    logic [7:0] msg [0:79];
    logic       calm = 1'b0;
    int         idle_cycles = 0;
    int         cycle_no = 0;
    int         stall_left = 0;
    int         items_sent = 0;

    icmp_echo_responder_unit #(
        .MAX_BYTES(MAX_BYTES)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tlast (s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    icmp_echo_reply_checker #(
        .MAX_BYTES(MAX_BYTES)
    ) reply_check (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tlast     (o_m_tlast),
        .o_mismatches  (mismatches),
        .o_waiting     (waiting),
        .o_replies_seen(replies_seen),
        .o_dropped     (dropped)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (!rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stalls in bursts, only while bit 7 of the cycle count is set and not calm
    always @(negedge i_clk) begin
        if (!rst_n) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && cycle_no[7] && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // echo request header with random code, identifier, sequence and data
    task automatic fill_request(input int len);
        for (int i = 0; i < len; i++) begin
            msg[i] = 8'($urandom);
        end
        msg[0] = ECHO_REQUEST_TYPE;
    endtask

    // checksum over the first len bytes, at most MAX_BYTES
    task automatic seal_checksum(input int len);
        int          lim;
        logic [15:0] sum;
        logic [7:0]  lo;
        lim = (len > MAX_BYTES) ? MAX_BYTES : len;
        msg[2] = 8'd0;
        msg[3] = 8'd0;
        sum = 16'd0;
        for (int i = 0; i < lim; i += 2) begin
            lo  = (i + 1 < lim) ? msg[i + 1] : 8'h00;
            sum = fold_add(sum, {msg[i], lo});
        end
        {msg[2], msg[3]} = ~sum;
    endtask

    // one request item, after an optional gap
    task automatic send_item(input logic [7:0] data, input logic last, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_message(input int len, input logic bursty);
        int gap;
        for (int i = 0; i < len; i++) begin
            gap = (bursty && !calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
            send_item(msg[i], i == len - 1, gap);
        end
    endtask

    // hold the sender off until every predicted reply item has come out
    task automatic drain_replies();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        int        len;
        int        pick;
        int        msg_no;
        int        directed_items;
        t_msg_kind kind;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // minimum length, shared words summing to all ones so the new checksum is zero
        fill_request(8);
        {msg[4], msg[5], msg[6], msg[7]} = {8'hFF, 8'hFF, 8'h00, 8'h00};
        seal_checksum(8);
        send_message(8, 1'b0);
        // a lone item carrying the last mark
        send_item(8'hFF, 1'b1, 0);
        // odd length with a non-zero code and a zero final byte
        fill_request(9);
        msg[1] = 8'hFF;
        msg[8] = 8'h00;
        seal_checksum(9);
        send_message(9, 1'b0);
        // an echo reply is not a request
        fill_request(8);
        msg[0] = ECHO_REPLY_TYPE;
        seal_checksum(8);
        send_message(8, 1'b0);
        directed_items = items_sent;
        drain_replies();

        // random messages, mostly well-formed requests
        msg_no = 0;
        while (items_sent - directed_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (msg_no == 4)
                kind = MSG_FULL;
            else if (msg_no == 9)
                kind = MSG_LONG;
            else if (pick < 60)
                kind = MSG_ECHO;
            else if (pick < 70)
                kind = MSG_SHORT;
            else if (pick < 80)
                kind = MSG_BAD_SUM;
            else if (pick < 90)
                kind = MSG_WRONG_TYPE;
            else
                kind = MSG_NOISE;

            case (kind)
                MSG_FULL: len = MAX_BYTES;
                MSG_LONG: len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 6);
                MSG_SHORT: len = $urandom_range(4, 7);
                MSG_NOISE: len = $urandom_range(1, 12);
                default: len = $urandom_range(8, 24);
            endcase

            fill_request(len);
            case (kind)
                MSG_WRONG_TYPE: begin
                    msg[0] = 8'($urandom);
                    if (msg[0] == ECHO_REQUEST_TYPE)
                        msg[0] = ECHO_REPLY_TYPE;
                end
                MSG_NOISE: msg[0] = 8'($urandom);
                default: ;
            endcase
            if (kind != MSG_NOISE) begin
                seal_checksum(len);
            end
            // a single flipped bit spoils the checksum
            if (kind == MSG_BAD_SUM) begin
                pick = $urandom_range(0, len - 1);
                msg[pick] = msg[pick] ^ (8'd1 << $urandom_range(0, 7));
            end

            send_message(len, $urandom_range(0, 2) != 0);
            msg_no++;
            if (msg_no == 6) begin
                drain_replies();
            end
            if (items_sent - directed_items >= CALM_FROM) begin
                calm <= 1'b1;
            end
        end

        // wind down
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (2 * MAX_BYTES + 8) @(posedge i_clk);

        $display("%0d request items sent (%0d directed, %0d messages random)",
                 items_sent, directed_items, msg_no);
        $display("%0d echo replies checked, %0d messages dropped by design",
                 replies_seen, dropped);
        if (mismatches == 0 && waiting == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: icmp_echo_responder_unit.f
rtl/icmp_echo_pkg.sv
rtl/icmp_echo_ram.sv
rtl/icmp_echo_front.sv
rtl/icmp_echo_queue.sv
rtl/icmp_echo_back.sv
rtl/icmp_echo_responder_unit.sv
tb/sv/icmp_echo_reply_checker.sv
tb/sv/icmp_echo_responder_unit_test.sv
